FILE: hw/rtl/lqsq_pkg.sv
// lqsq_pkg: shared types and constants for the linear queue with stat queries
// used by the front, the back and the top level; no dependencies
`default_nettype none

package lqsq_pkg;

  // command codes on the input beat
  localparam logic [1:0] CMD_ENQ = 2'd0;
  localparam logic [1:0] CMD_DEQ = 2'd1;
  localparam logic [1:0] CMD_MID = 2'd2;
  localparam logic [1:0] CMD_SEC = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_FEW      = 3'd3;
  localparam logic [2:0] ST_NOSECOND = 3'd4;

  // flips signed order into unsigned order
  localparam logic [31:0] SIGN_BIT = 32'h8000_0000;

  // command queue between front and back
  localparam int CQ_DEPTH = 2;
  localparam int CQ_PW    = $clog2(CQ_DEPTH);
  localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_ENQ,
    OP_DEQ,
    OP_MID,
    OP_SEC
  } op_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] value;
  } cmd_t;

  // front-to-back command handshake
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cq_out_t;

endpackage

`default_nettype wire

FILE: hw/rtl/linear_queue_with_stat_queries_top.sv
// linear_queue_with_stat_queries_top: array queue of signed 32-bit values with
// middle and second-largest queries; depends on lqsq_pkg, lqsq_front, lqsq_back
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   in_command[1:0], in_value[31:0]
//   out      output     out_valid/out_stall out_status[2:0], out_data[31:0]
//
// enqueue and failed commands give their result in the cycle after leaving the
// command queue; dequeue and middle first read the entry ram (one ram read).
// second largest folds in all n stored entries, up to DEPTH, before its result:
// the scan reads the entry ram one position per cycle through its single port.
// reset clears the positions, queues, state and result valid only; the entry ram is not cleared.
// out_stall holds the result register; the back waits for it before starting
// the next command, while the front keeps taking beats until its queue fills.
`default_nettype none

module linear_queue_with_stat_queries_top
  import lqsq_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_command,
  input  wire logic [31:0] in_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [31:0]      out_data
);

  cq_out_t cq;
  logic    cq_pop;

  // accept and classify
  lqsq_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .in_value   (in_value),
    .cq_out     (cq),
    .cq_pop     (cq_pop)
  );

  // execute against the entry store
  lqsq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cq_in      (cq),
    .cq_pop     (cq_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_status (out_status),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/lqsq_ram.sv
// lqsq_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module lqsq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lqsq_front.sv
// lqsq_front: accepts input beats, classifies the command and holds it in a
// short command queue for the back; depends on lqsq_pkg
`default_nettype none

module lqsq_front
  import lqsq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_command,
  input  wire logic [31:0] in_value,
  output cq_out_t          cq_out,
  input  wire logic        cq_pop
);

  cmd_t             q_mem_r [CQ_DEPTH];
  logic [CQ_PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CQ_PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CQ_CW-1:0] cnt_r, cnt_nxt;
  logic             push;
  cmd_t             cls;

  // classify the command code
  always_comb begin
    cls.value = in_value;
    case (in_command)
      CMD_ENQ: cls.op = OP_ENQ;
      CMD_DEQ: cls.op = OP_DEQ;
      CMD_MID: cls.op = OP_MID;
      CMD_SEC: cls.op = OP_SEC;
      default: cls.op = OP_SEC;
    endcase
  end

  assign in_stall   = (cnt_r == CQ_CW'(CQ_DEPTH));
  assign push       = in_valid && !in_stall;
  assign cq_out.valid = (cnt_r != '0);
  assign cq_out.cmd   = q_mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == CQ_PW'(CQ_DEPTH - 1)) ? '0 : wr_ptr_r + CQ_PW'(1);
    end
    if (cq_pop) begin
      rd_ptr_nxt = (rd_ptr_r == CQ_PW'(CQ_DEPTH - 1)) ? '0 : rd_ptr_r + CQ_PW'(1);
    end
    if (push && !cq_pop) begin
      cnt_nxt = cnt_r + CQ_CW'(1);
    end else if (!push && cq_pop) begin
      cnt_nxt = cnt_r - CQ_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lqsq_back.sv
// lqsq_back: executes queued commands against the entry ram, runs the
// second-largest scan and drives the result register; depends on lqsq_pkg, lqsq_ram
`default_nettype none

module lqsq_back
  import lqsq_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cq_out_t     cq_in,
  output logic             cq_pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [31:0]      out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_SCAN
  } state_t;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   head_r, head_nxt;
  logic [CW-1:0]   tail_r, tail_nxt;
  logic [CW-1:0]   scan_idx_r, scan_idx_nxt;
  logic [31:0]     best_r, best_nxt;
  logic [31:0]     second_r, second_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [2:0]      out_status_r, out_status_nxt;
  logic [31:0]     out_data_r, out_data_nxt;

  logic            out_free;
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [31:0]     ram_rdata;
  logic [CW-1:0]   head_ext, head_inc;
  logic [CW:0]     mid_sum;
  logic [AW-1:0]   mid_addr;
  logic [31:0]     scan_x;
  logic [31:0]     best_upd, second_upd;

  lqsq_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (cq_in.cmd.value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // position arithmetic
  assign head_ext = CW'(head_r);
  assign head_inc = head_ext + CW'(1);
  assign mid_sum  = (CW + 1)'(head_r) + (CW + 1)'(tail_r) - (CW + 1)'(1);
  assign mid_addr = mid_sum[AW:1];
  assign ram_waddr = tail_r[AW-1:0];

  // one step of the running max / second max, in offset-binary order
  assign scan_x = ram_rdata ^ SIGN_BIT;
  always_comb begin
    best_upd   = best_r;
    second_upd = second_r;
    if (scan_x > best_r) begin
      second_upd = best_r;
      best_upd   = scan_x;
    end else if ((scan_x > second_r) && (scan_x != best_r)) begin
      second_upd = scan_x;
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign cq_pop   = (state_r == S_IDLE) && cq_in.valid && out_free;

  // command sequencing
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    scan_idx_nxt   = scan_idx_r;
    best_nxt       = best_r;
    second_nxt     = second_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_raddr      = head_r;

    case (state_r)
      S_IDLE: begin
        if (cq_pop) begin
          case (cq_in.cmd.op)
            OP_ENQ: begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '0;
              if (tail_r == CW'(DEPTH)) begin
                out_status_nxt = ST_FULL;
              end else begin
                ram_we         = 1'b1;
                tail_nxt       = tail_r + CW'(1);
                out_status_nxt = ST_OK;
              end
            end
            OP_DEQ: begin
              if (tail_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_EMPTY;
                out_data_nxt   = '0;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = head_r;
                state_nxt = S_RD;
                // queue drained: both positions restart at zero
                if (head_inc >= tail_r) begin
                  head_nxt = '0;
                  tail_nxt = '0;
                end else begin
                  head_nxt = head_inc[AW-1:0];
                end
              end
            end
            OP_MID: begin
              if (tail_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_EMPTY;
                out_data_nxt   = '0;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = mid_addr;
                state_nxt = S_RD;
              end
            end
            OP_SEC: begin
              if ((tail_r == '0) || ((tail_r - CW'(1)) <= head_ext)) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_FEW;
                out_data_nxt   = '0;
              end else begin
                ram_re       = 1'b1;
                ram_raddr    = head_r;
                scan_idx_nxt = head_inc;
                best_nxt     = '0;
                second_nxt   = '0;
                state_nxt    = S_SCAN;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_RD: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_OK;
        out_data_nxt   = ram_rdata;
        state_nxt      = S_IDLE;
      end
      S_SCAN: begin
        best_nxt   = best_upd;
        second_nxt = second_upd;
        if (scan_idx_r < tail_r) begin
          ram_re       = 1'b1;
          ram_raddr    = scan_idx_r[AW-1:0];
          scan_idx_nxt = scan_idx_r + CW'(1);
        end else begin
          // last entry folded in this cycle
          out_valid_nxt = 1'b1;
          if (second_upd == '0) begin
            out_status_nxt = ST_NOSECOND;
            out_data_nxt   = '0;
          end else begin
            out_status_nxt = ST_OK;
            out_data_nxt   = second_upd ^ SIGN_BIT;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
    scan_idx_r   <= scan_idx_nxt;
    best_r       <= best_nxt;
    second_r     <= second_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_data   = out_data_r;

  // write position never passes the end of the store
  a_tail_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tail_r <= CW'(DEPTH))
    else $error("tail position beyond depth");

  // read position stays below write position, and is zero when empty
  a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
    (tail_r != '0) |-> (head_ext < tail_r))
    else $error("head not below tail");

  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    (tail_r == '0) |-> (head_r == '0))
    else $error("head nonzero on empty queue");

  // a read result always finds the result register free
  a_rd_slot: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_RD) || (state_r == S_SCAN)) |-> !out_valid_r)
    else $error("result register busy during read");

  // failed commands carry zero data
  a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_OK)) |-> (out_data_r == '0))
    else $error("nonzero data with error status");

endmodule

`default_nettype wire
